// ----- design/aot_pkg.sv -----
// Shared constants for the box-pair overlap test pipeline.
package aot_pkg;

	// Width of every packed input port
	localparam int FIELD_BITS = 48;

	// Number of components per vector and number of oriented axes
	localparam int NUM_DIMS = 3;

endpackage

// ----- design/aabb_obb_overlap_test.sv -----
// Box-pair overlap test: six-axis separating-axis check, four register stages.
// Throughput: one pair per cycle while pair_stall is low. The four stages each hold
// one pair, and a stage that holds no pair is filled even while a later one stalls.
// The depth is set by decode, products, sums and compare, one per stage.
// Reset (arst_n low) clears all stage valid bits at once; payload is not reset.
module aabb_obb_overlap_test #(
	parameter int COORD_BITS     = 16,
	parameter int AXIS_FRAC_BITS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pair_valid,
	output logic                           pair_stall,
	input  logic [aot_pkg::FIELD_BITS-1:0] box_min,
	input  logic [aot_pkg::FIELD_BITS-1:0] box_max,
	input  logic [aot_pkg::FIELD_BITS-1:0] obb_center,
	input  logic [aot_pkg::FIELD_BITS-1:0] obb_axis_u,
	input  logic [aot_pkg::FIELD_BITS-1:0] obb_axis_v,
	input  logic [aot_pkg::FIELD_BITS-1:0] obb_axis_w,
	input  logic [aot_pkg::FIELD_BITS-1:0] obb_extent,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic                           overlap
);

	localparam int ND   = aot_pkg::NUM_DIMS;
	localparam int AB   = AXIS_FRAC_BITS + 2;     // axis component width
	localparam int TW   = COORD_BITS + 2;         // doubled centre difference
	localparam int DW   = COORD_BITS + 1;         // box size
	localparam int PW   = COORD_BITS + AB + 2;    // product width
	localparam int W    = PW + 3;                 // sum and compare width
	localparam int CPAD = (ND * COORD_BITS > aot_pkg::FIELD_BITS) ?
	                      ND * COORD_BITS : aot_pkg::FIELD_BITS;
	localparam int APAD = (ND * AB > aot_pkg::FIELD_BITS) ? ND * AB : aot_pkg::FIELD_BITS;

	// Handshake and stage advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4       = !v_s4 || !res_stall;
	assign adv3       = !v_s3 || adv4;
	assign adv2       = !v_s2 || adv3;
	assign adv1       = !v_s1 || adv2;
	assign pair_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pair_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Field decode, zero padded past the port top
	logic [CPAD-1:0] min_pad, max_pad, ctr_pad, ext_pad;
	logic [APAD-1:0] axu_pad, axv_pad, axw_pad;

	assign min_pad = CPAD'(box_min);
	assign max_pad = CPAD'(box_max);
	assign ctr_pad = CPAD'(obb_center);
	assign ext_pad = CPAD'(obb_extent);
	assign axu_pad = APAD'(obb_axis_u);
	assign axv_pad = APAD'(obb_axis_v);
	assign axw_pad = APAD'(obb_axis_w);

	logic signed [COORD_BITS-1:0] lo_c [ND];
	logic signed [COORD_BITS-1:0] hi_c [ND];
	logic signed [COORD_BITS-1:0] cc_c [ND];
	logic signed [TW-1:0]         t2_c [ND];
	logic signed [DW-1:0]         d_c  [ND];
	logic        [COORD_BITS-1:0] s_c  [ND];
	logic signed [AB-1:0]         ax_c [ND][ND];

	// Stage 1: unpack, doubled centre difference and box size
	always_comb begin
		for (int k = 0; k < ND; k++) begin
			lo_c[k]    = $signed(min_pad[k*COORD_BITS +: COORD_BITS]);
			hi_c[k]    = $signed(max_pad[k*COORD_BITS +: COORD_BITS]);
			cc_c[k]    = $signed(ctr_pad[k*COORD_BITS +: COORD_BITS]);
			s_c[k]     = ext_pad[k*COORD_BITS +: COORD_BITS];
			t2_c[k]    = TW'(lo_c[k]) + TW'(hi_c[k]) - (TW'(cc_c[k]) <<< 1);
			d_c[k]     = DW'(hi_c[k]) - DW'(lo_c[k]);
			ax_c[0][k] = $signed(axu_pad[k*AB +: AB]);
			ax_c[1][k] = $signed(axv_pad[k*AB +: AB]);
			ax_c[2][k] = $signed(axw_pad[k*AB +: AB]);
		end
	end

	logic signed [TW-1:0]         t2_s1 [ND];
	logic signed [DW-1:0]         d_s1  [ND];
	logic        [COORD_BITS-1:0] s_s1  [ND];
	logic signed [AB-1:0]         ax_s1 [ND][ND];

	always_ff @(posedge clk) begin
		if (adv1 && pair_valid) begin
			t2_s1 <= t2_c;
			d_s1  <= d_c;
			s_s1  <= s_c;
			ax_s1 <= ax_c;
		end
	end

	// Stage 2: the 27 projection products
	logic signed [PW-1:0] pt_c [ND][ND];
	logic signed [PW-1:0] pd_c [ND][ND];
	logic signed [PW-1:0] ps_c [ND][ND];

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			for (int k = 0; k < ND; k++) begin
				pt_c[i][k] = PW'(t2_s1[k]) * PW'(ax_s1[i][k]);
				pd_c[i][k] = PW'(d_s1[k]) * PW'(ax_s1[i][k]);
				ps_c[i][k] = PW'($signed({1'b0, s_s1[i]})) * PW'(ax_s1[i][k]);
			end
		end
	end

	logic signed [PW-1:0]         pt_s2 [ND][ND];
	logic signed [PW-1:0]         pd_s2 [ND][ND];
	logic signed [PW-1:0]         ps_s2 [ND][ND];
	logic signed [TW-1:0]         t2_s2 [ND];
	logic signed [DW-1:0]         d_s2  [ND];
	logic        [COORD_BITS-1:0] s_s2  [ND];

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			pt_s2 <= pt_c;
			pd_s2 <= pd_c;
			ps_s2 <= ps_c;
			t2_s2 <= t2_s1;
			d_s2  <= d_s1;
			s_s2  <= s_s1;
		end
	end

	// Stage 3: distances and radius sums per axis
	logic signed [W-1:0] dist_c  [ND];
	logic signed [W-1:0] mdist_c [ND];
	logic signed [W-1:0] rado_c  [ND];
	logic signed [W-1:0] tw_c    [ND];
	logic signed [W-1:0] radw_c  [ND];
	logic signed [W-1:0] apd_c   [ND][ND];
	logic signed [W-1:0] aps_c   [ND][ND];
	logic signed [W-1:0] t2w_c   [ND];

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			for (int k = 0; k < ND; k++) begin
				apd_c[i][k] = pd_s2[i][k][PW-1] ? -W'(pd_s2[i][k]) : W'(pd_s2[i][k]);
				aps_c[i][k] = ps_s2[i][k][PW-1] ? -W'(ps_s2[i][k]) : W'(ps_s2[i][k]);
			end
		end
		// oriented axes
		for (int i = 0; i < ND; i++) begin
			dist_c[i]  = W'(pt_s2[i][0]) + W'(pt_s2[i][1]) + W'(pt_s2[i][2]);
			mdist_c[i] = dist_c[i][W-1] ? -dist_c[i] : dist_c[i];
			rado_c[i]  = (W'($signed({1'b0, s_s2[i]})) <<< AXIS_FRAC_BITS)
			             + apd_c[i][0] + apd_c[i][1] + apd_c[i][2];
		end
		// world axes
		for (int k = 0; k < ND; k++) begin
			t2w_c[k]  = t2_s2[k][TW-1] ? -W'(t2_s2[k]) : W'(t2_s2[k]);
			tw_c[k]   = t2w_c[k] <<< AXIS_FRAC_BITS;
			radw_c[k] = (W'(d_s2[k]) <<< AXIS_FRAC_BITS)
			            + aps_c[0][k] + aps_c[1][k] + aps_c[2][k];
		end
	end

	logic signed [W-1:0] mdist_s3 [ND];
	logic signed [W-1:0] rado_s3  [ND];
	logic signed [W-1:0] tw_s3    [ND];
	logic signed [W-1:0] radw_s3  [ND];

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			mdist_s3 <= mdist_c;
			rado_s3  <= rado_c;
			tw_s3    <= tw_c;
			radw_s3  <= radw_c;
		end
	end

	// Stage 4: compare on all six axes; a tie does not separate
	logic sep_c;

	always_comb begin
		sep_c = 1'b0;
		for (int i = 0; i < ND; i++) begin
			if (mdist_s3[i] > rado_s3[i]) sep_c = 1'b1;
			if (tw_s3[i] > radw_s3[i])    sep_c = 1'b1;
		end
	end

	logic overlap_s4;

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			overlap_s4 <= !sep_c;
		end
	end

	assign res_valid = v_s4;
	assign overlap   = overlap_s4;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the box-pair overlap test: predicted results, random handshakes.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W   = 16;
	localparam int AXIS_FRAC = 14;
	localparam int AXIS_W    = AXIS_FRAC + 2;
	localparam int ONE_AXIS  = 1 << AXIS_FRAC;

	typedef logic [aot_pkg::FIELD_BITS-1:0] field_t;

	// One box pair as it appears on the input ports
	typedef struct packed {
		field_t box_min;
		field_t box_max;
		field_t obb_center;
		field_t obb_axis_u;
		field_t obb_axis_v;
		field_t obb_axis_w;
		field_t obb_extent;
	} pair_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   pair_valid;
	logic   pair_stall;
	field_t box_min, box_max, obb_center;
	field_t obb_axis_u, obb_axis_v, obb_axis_w, obb_extent;
	logic   res_valid;
	logic   res_stall;
	logic   overlap;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	aabb_obb_overlap_test #(
		.COORD_BITS     (COORD_W),
		.AXIS_FRAC_BITS (AXIS_FRAC)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.box_min    (box_min),
		.box_max    (box_max),
		.obb_center (obb_center),
		.obb_axis_u (obb_axis_u),
		.obb_axis_v (obb_axis_v),
		.obb_axis_w (obb_axis_w),
		.obb_extent (obb_extent),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.overlap    (overlap)
	);

	always #1 clk = ~clk;

	// Component extraction; a component lying wholly above bit 63 reads as zero
	function automatic longint comp_bits(field_t word, int pos, int w, bit is_signed);
		logic [63:0] wide;
		longint      v;
		if (pos >= 64)
			return 0;
		wide = 64'(word);
		v = longint'((wide >> pos) & ((64'd1 << w) - 64'd1));
		if (is_signed && v[w-1])
			v = v - (longint'(1) << w);
		return v;
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Six-axis separation test on doubled, exactly scaled integers
	function automatic bit predict_overlap(pair_t p);
		longint t2[3], d[3], s[3], ax[3][3];
		longint proj, rad, lo, hi, c;
		longint scale;
		bit     sep;
		field_t axes[3];
		scale   = longint'(1) << AXIS_FRAC;
		sep     = 1'b0;
		axes[0] = p.obb_axis_u;
		axes[1] = p.obb_axis_v;
		axes[2] = p.obb_axis_w;
		for (int k = 0; k < aot_pkg::NUM_DIMS; k++) begin
			lo    = comp_bits(p.box_min, k * COORD_W, COORD_W, 1'b1);
			hi    = comp_bits(p.box_max, k * COORD_W, COORD_W, 1'b1);
			c     = comp_bits(p.obb_center, k * COORD_W, COORD_W, 1'b1);
			t2[k] = lo + hi - 2 * c;
			d[k]  = hi - lo;
			s[k]  = comp_bits(p.obb_extent, k * COORD_W, COORD_W, 1'b0);
			for (int i = 0; i < aot_pkg::NUM_DIMS; i++)
				ax[i][k] = comp_bits(axes[i], k * AXIS_W, AXIS_W, 1'b1);
		end
		// oriented axes
		for (int i = 0; i < aot_pkg::NUM_DIMS; i++) begin
			proj = 0;
			rad  = s[i] * scale;
			for (int k = 0; k < aot_pkg::NUM_DIMS; k++) begin
				proj += t2[k] * ax[i][k];
				rad  += magnitude(d[k] * ax[i][k]);
			end
			if (magnitude(proj) > rad)
				sep = 1'b1;
		end
		// world axes
		for (int k = 0; k < aot_pkg::NUM_DIMS; k++) begin
			rad = d[k] * scale;
			for (int i = 0; i < aot_pkg::NUM_DIMS; i++)
				rad += magnitude(s[i] * ax[i][k]);
			if (magnitude(t2[k]) * scale > rad)
				sep = 1'b1;
		end
		return !sep;
	endfunction

	// Expected overlap flags, oldest first
	class overlap_ledger;
		bit expected_q[$];
		int fails;

		function void note_pair(pair_t p);
			expected_q.push_back(predict_overlap(p));
		endfunction

		function void check_result(logic actual);
			bit want;
			if (expected_q.size() == 0) begin
				$error("overlap: expected none pending, actual %0b", actual);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			if (actual !== want) begin
				$error("overlap: expected %0b, actual %0b", want, actual);
				fails++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	overlap_ledger ledger = new;

	function automatic field_t pack3(int x, int y, int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic field_t rand_field();
		return field_t'({$urandom, $urandom});
	endfunction

	// Drive one pair transaction and note it once accepted
	task automatic send_pair(pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pair_valid <= 1'b0;
			@(negedge clk);
		end
		box_min    <= p.box_min;
		box_max    <= p.box_max;
		obb_center <= p.obb_center;
		obb_axis_u <= p.obb_axis_u;
		obb_axis_v <= p.obb_axis_v;
		obb_axis_w <= p.obb_axis_w;
		obb_extent <= p.obb_extent;
		pair_valid <= 1'b1;
		@(posedge clk);
		while (pair_stall)
			@(posedge clk);
		ledger.note_pair(p);
		@(negedge clk);
	endtask

	// Axis-aligned box of given centre and half sizes against an oriented box
	function automatic pair_t make_pair(int bx, int by, int bz, int hx, int hy, int hz,
			int cx, int cy, int cz, field_t u, field_t v, field_t w,
			int sx, int sy, int sz);
		pair_t p;
		p.box_min    = pack3(bx - hx, by - hy, bz - hz);
		p.box_max    = pack3(bx + hx, by + hy, bz + hz);
		p.obb_center = pack3(cx, cy, cz);
		p.obb_axis_u = u;
		p.obb_axis_v = v;
		p.obb_axis_w = w;
		p.obb_extent = pack3(sx, sy, sz);
		return p;
	endfunction

	// Random pair: rotated unit axes, boxes near each other, some skewed axes and inverted boxes
	function automatic pair_t random_scene();
		int    cs[4][2] = '{'{16384, 0}, '{15137, 6270}, '{11585, 11585}, '{6270, 15137}};
		int    m[3][3];
		int    r, c, s, tmp;
		int    bc[3], h[3], oc[3], ext[3];
		pair_t p;
		r = $urandom_range(3);
		c = cs[r][0];
		s = cs[r][1];
		if ($urandom_range(1))
			s = -s;
		case ($urandom_range(2))
			0: m = '{'{c, s, 0}, '{-s, c, 0}, '{0, 0, ONE_AXIS}};
			1: m = '{'{ONE_AXIS, 0, 0}, '{0, c, s}, '{0, -s, c}};
			default: m = '{'{c, 0, -s}, '{0, ONE_AXIS, 0}, '{s, 0, c}};
		endcase
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(1))
				for (int k = 0; k < 3; k++)
					m[i][k] = -m[i][k];
			// occasional skewed, non-unit axis
			if ($urandom_range(9) == 0)
				for (int k = 0; k < 3; k++)
					m[i][k] = m[i][k] + $urandom_range(2000) - 1000;
		end
		for (int k = 0; k < 3; k++) begin
			bc[k]  = $urandom_range(12000) - 6000;
			h[k]   = $urandom_range(3000);
			oc[k]  = bc[k] + $urandom_range(8000) - 4000;
			ext[k] = $urandom_range(6000);
		end
		p = make_pair(bc[0], bc[1], bc[2], h[0], h[1], h[2], oc[0], oc[1], oc[2],
			pack3(m[0][0], m[0][1], m[0][2]), pack3(m[1][0], m[1][1], m[1][2]),
			pack3(m[2][0], m[2][1], m[2][2]), ext[0], ext[1], ext[2]);
		// occasional inverted box: min above max
		if ($urandom_range(9) == 0) begin
			tmp = $urandom_range(2);
			{p.box_min[tmp*16 +: 16], p.box_max[tmp*16 +: 16]} =
				{p.box_max[tmp*16 +: 16], p.box_min[tmp*16 +: 16]};
		end
		return p;
	endfunction

	// Receiver side stall
	always @(negedge clk) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			ledger.check_result(overlap);
	end

	// Run time limit
	initial begin
		#400_000;
		$display("aabb_obb_overlap_test: mismatch");
		$finish;
	end

	// Main sequence
	initial begin
		pair_t  p;
		field_t ux, uy, uz, d45u, d45v;
		int     idle_tab[4]  = '{0, 73, 0, 15};
		int     stall_tab[4] = '{0, 0, 73, 15};

		arst_n     = 1'b0;
		pair_valid = 1'b0;
		box_min    = '0;
		box_max    = '0;
		obb_center = '0;
		obb_axis_u = '0;
		obb_axis_v = '0;
		obb_axis_w = '0;
		obb_extent = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		ux   = pack3(ONE_AXIS, 0, 0);
		uy   = pack3(0, ONE_AXIS, 0);
		uz   = pack3(0, 0, ONE_AXIS);
		d45u = pack3(11585, 11585, 0);
		d45v = pack3(-11585, 11585, 0);

		// Directed: field extremes
		send_pair('0);
		send_pair('1);
		p = '{default: pack3(16'h7fff, 16'h7fff, 16'h7fff)};
		p.obb_extent = '1;
		send_pair(p);
		p = '{default: pack3(16'h8000, 16'h8000, 16'h8000)};
		send_pair(p);
		p = '{default: pack3(16'h8000, 16'h7fff, 16'h0001)};
		p.box_max = pack3(16'h7fff, 16'h8000, 16'hffff);
		send_pair(p);
		// Directed: plain overlap, separation on each world axis, touching faces
		send_pair(make_pair(0, 0, 0, 256, 256, 256, 0, 0, 0, ux, uy, uz, 512, 512, 512));
		send_pair(make_pair(0, 0, 0, 256, 256, 256, 768, 0, 0, ux, uy, uz, 256, 512, 512));
		send_pair(make_pair(0, 0, 0, 256, 256, 256, 512, 0, 0, ux, uy, uz, 512, 512, 512));
		send_pair(make_pair(0, 0, 0, 256, 256, 256, 0, -900, 0, ux, uy, uz, 512, 512, 512));
		send_pair(make_pair(0, 0, 0, 256, 256, 256, 0, 0, 1000, ux, uy, uz, 512, 512, 512));
		send_pair(make_pair(0, 0, 0, 256, 256, 256, 0, 0, -768, ux, uy, uz, 512, 512, 512));
		// Directed: rotated box apart along a diagonal, then closer and overlapping
		send_pair(make_pair(0, 0, 0, 256, 256, 256, 600, 600, 0, d45u, d45v, uz,
			128, 2048, 256));
		send_pair(make_pair(0, 0, 0, 256, 256, 256, 400, 400, 0, d45u, d45v, uz,
			512, 512, 512));
		// Directed: long box against a rotated box, separated on a diagonal oriented axis
		send_pair(make_pair(0, 0, 0, 256, 256, 2560, 500, 500, 0,
			pack3(11585, -11585, 0), pack3(0, 0, ONE_AXIS), pack3(11585, 11585, 0),
			128, 512, 128));
		// Directed: non-unit axes and a box with min above max
		send_pair(make_pair(0, 0, 0, 256, 256, 256, 900, 0, 0,
			pack3(32767, 0, 0), pack3(0, 32767, 0), pack3(-32768, 0, 0), 256, 256, 256));
		send_pair(make_pair(0, 0, 0, -256, 256, 256, 600, 0, 0, ux, uy, uz, 512, 512, 512));
		send_pair(make_pair(0, 0, 0, -256, 256, 256, 0, 0, 0, d45u, d45v, uz, 0, 0, 0));
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, '0, '0, '0, 16'hffff, 0, 0));

		// Random phases with different idle and stall pressure
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			for (int n = 0; n < 320; n++) begin
				if ($urandom_range(4) == 0)
					p = '{rand_field(), rand_field(), rand_field(), rand_field(),
						rand_field(), rand_field(), rand_field()};
				else
					p = random_scene();
				send_pair(p);
			end
		end
		pair_valid <= 1'b0;

		// Drain
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (ledger.fails == 0 && ledger.pending() == 0)
			$display("aabb_obb_overlap_test: match");
		else
			$display("aabb_obb_overlap_test: mismatch");
		$finish;
	end

endmodule
